FILE: hdl/pcn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_pkg
// Shared constants of the cell noise evaluator: gradient index
// codes, fade polynomial coefficients and pipeline geometry.
// ----------------------------------------------------------------------------
package pcn_pkg;

	// Width of one corner gradient index and number of cell corners.
	localparam int GRAD_W      = 4;
	localparam int NUM_CORNERS = 8;

	// Pipeline depth from input register to output register.
	localparam int NUM_STAGES  = 11;

	// Gradient index codes. Each names the signed sum of two corner offsets.
	localparam logic [GRAD_W-1:0] GRAD_PX_PY = 4'd0;
	localparam logic [GRAD_W-1:0] GRAD_NX_PY = 4'd1;
	localparam logic [GRAD_W-1:0] GRAD_PX_NY = 4'd2;
	localparam logic [GRAD_W-1:0] GRAD_NX_NY = 4'd3;
	localparam logic [GRAD_W-1:0] GRAD_PX_PZ = 4'd4;
	localparam logic [GRAD_W-1:0] GRAD_NX_PZ = 4'd5;
	localparam logic [GRAD_W-1:0] GRAD_PX_NZ = 4'd6;
	localparam logic [GRAD_W-1:0] GRAD_NX_NZ = 4'd7;
	localparam logic [GRAD_W-1:0] GRAD_PY_PZ = 4'd8;
	localparam logic [GRAD_W-1:0] GRAD_NY_PZ = 4'd9;
	localparam logic [GRAD_W-1:0] GRAD_PY_NZ = 4'd10;
	localparam logic [GRAD_W-1:0] GRAD_NY_NZ = 4'd11;

	// Highest legal gradient index.
	localparam logic [GRAD_W-1:0] GRAD_MAX   = GRAD_NY_NZ;

	// Fade polynomial 6t^5 - 15t^4 + 10t^3, evaluated as t^3 * (6t^2 - 15t + 10).
	localparam int FADE_C2 = 6;
	localparam int FADE_C1 = 15;
	localparam int FADE_C0 = 10;

endpackage
`default_nettype wire

FILE: hdl/pcn_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_fade
// Four-stage fade weight unit for one axis: w = t^3 * (6t^2 - 15t + 10),
// one multiplier in stages 1 to 3, rounded half up, limited to one.
// ----------------------------------------------------------------------------
module pcn_fade #(
	parameter int F = 16
) (
	input  wire logic         clk,
	input  wire logic [3:0]   en,
	input  wire logic [F-1:0] t,
	output logic      [F:0]   w
);

	localparam int TW = 2 * F;
	localparam int QW = F + 5;
	localparam int PW = 2 * F + 4;
	localparam logic [TW:0]   HALF_T = (TW + 1)'(1) << (F - 1);
	localparam logic [PW:0]   HALF_P = (PW + 1)'(1) << (F - 1);
	localparam logic [F+4:0]  ONE_W  = (F + 5)'(1) << F;

	logic [F-1:0]  t_s1;
	logic [TW-1:0] tt_s1;
	logic [TW-1:0] cp_s2;
	logic [F+3:0]  q_s2;
	logic [PW-1:0] wp_s3;
	logic [F:0]    w_s4;

	logic [TW:0]   s_sum;
	logic [F-1:0]  s_rnd;
	logic [QW-1:0] q_pos;
	logic [QW-1:0] q_neg;
	logic [QW-1:0] q_sum;
	logic [TW:0]   c_sum;
	logic [F-1:0]  c_rnd;
	logic [PW:0]   w_sum;
	logic [F+4:0]  w_rnd;

	always_comb begin
		s_sum = (TW + 1)'(tt_s1) + HALF_T;
		s_rnd = s_sum[F +: F];
		q_pos = QW'(pcn_pkg::FADE_C2) * QW'(s_rnd) + (QW'(pcn_pkg::FADE_C0) << F);
		q_neg = QW'(pcn_pkg::FADE_C1) * QW'(t_s1);
		q_sum = q_pos - q_neg;
		c_sum = (TW + 1)'(cp_s2) + HALF_T;
		c_rnd = c_sum[F +: F];
		w_sum = (PW + 1)'(wp_s3) + HALF_P;
		w_rnd = w_sum[F +: F + 5];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1  <= t;
			tt_s1 <= TW'(t) * TW'(t);
		end
		if (en[1]) begin
			cp_s2 <= TW'(s_rnd) * TW'(t_s1);
			// The quadratic factor never goes negative on [0, 1), but clamp anyway.
			q_s2  <= q_sum[QW-1] ? '0 : q_sum[QW-2:0];
		end
		if (en[2]) begin
			wp_s3 <= PW'(c_rnd) * PW'(q_s2);
		end
		if (en[3]) begin
			w_s4 <= (w_rnd > ONE_W) ? ONE_W[F:0] : w_rnd[F:0];
		end
	end

	assign w = w_s4;

endmodule
`default_nettype wire

FILE: hdl/pcn_grad.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_grad
// Corner gradient dot products and index check, registered and then carried
// alongside the fade units so that they line up with the weights.
// ----------------------------------------------------------------------------
module pcn_grad #(
	parameter int F = 16
) (
	input  wire logic                          clk,
	input  wire logic [3:0]                    en,
	input  wire logic [F-1:0]                  frac_x,
	input  wire logic [F-1:0]                  frac_y,
	input  wire logic [F-1:0]                  frac_z,
	input  wire logic [pcn_pkg::GRAD_W-1:0]    grad [pcn_pkg::NUM_CORNERS],
	output logic signed [F+2:0]                dot  [pcn_pkg::NUM_CORNERS],
	output logic                               bad
);

	localparam int DW = F + 3;
	localparam logic signed [DW-1:0] ONE_D = DW'(1) << F;

	logic signed [DW-1:0] dot_s1 [pcn_pkg::NUM_CORNERS];
	logic signed [DW-1:0] dot_s2 [pcn_pkg::NUM_CORNERS];
	logic signed [DW-1:0] dot_s3 [pcn_pkg::NUM_CORNERS];
	logic signed [DW-1:0] dot_s4 [pcn_pkg::NUM_CORNERS];
	logic                 bad_s1, bad_s2, bad_s3, bad_s4;

	logic signed [DW-1:0] off_x [2];
	logic signed [DW-1:0] off_y [2];
	logic signed [DW-1:0] off_z [2];
	logic signed [DW-1:0] dot_c [pcn_pkg::NUM_CORNERS];
	logic                 bad_c;

	function automatic logic signed [DW-1:0] grad_dot(
		input logic [pcn_pkg::GRAD_W-1:0] k,
		input logic signed [DW-1:0]       a,
		input logic signed [DW-1:0]       b,
		input logic signed [DW-1:0]       c
	);
		logic signed [DW-1:0] r;
		case (k)
			pcn_pkg::GRAD_PX_PY: r =  a + b;
			pcn_pkg::GRAD_NX_PY: r = -a + b;
			pcn_pkg::GRAD_PX_NY: r =  a - b;
			pcn_pkg::GRAD_NX_NY: r = -a - b;
			pcn_pkg::GRAD_PX_PZ: r =  a + c;
			pcn_pkg::GRAD_NX_PZ: r = -a + c;
			pcn_pkg::GRAD_PX_NZ: r =  a - c;
			pcn_pkg::GRAD_NX_NZ: r = -a - c;
			pcn_pkg::GRAD_PY_PZ: r =  b + c;
			pcn_pkg::GRAD_NY_PZ: r = -b + c;
			pcn_pkg::GRAD_PY_NZ: r =  b - c;
			pcn_pkg::GRAD_NY_NZ: r = -b - c;
			default:             r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		off_x[0] = $signed(DW'(frac_x));
		off_y[0] = $signed(DW'(frac_y));
		off_z[0] = $signed(DW'(frac_z));
		off_x[1] = off_x[0] - ONE_D;
		off_y[1] = off_y[0] - ONE_D;
		off_z[1] = off_z[0] - ONE_D;
		bad_c    = 1'b0;
		// Corner number bit 0 selects the x offset, bit 1 y, bit 2 z.
		for (int i = 0; i < pcn_pkg::NUM_CORNERS; i++) begin
			dot_c[i] = grad_dot(grad[i], off_x[i % 2], off_y[(i / 2) % 2],
				off_z[(i / 4) % 2]);
			if (grad[i] > pcn_pkg::GRAD_MAX) begin
				bad_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dot_s1 <= dot_c;
			bad_s1 <= bad_c;
		end
		if (en[1]) begin
			dot_s2 <= dot_s1;
			bad_s2 <= bad_s1;
		end
		if (en[2]) begin
			dot_s3 <= dot_s2;
			bad_s3 <= bad_s2;
		end
		if (en[3]) begin
			dot_s4 <= dot_s3;
			bad_s4 <= bad_s3;
		end
	end

	assign dot = dot_s4;
	assign bad = bad_s4;

endmodule
`default_nettype wire

FILE: hdl/pcn_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_lerp
// Two-stage linear blend e = a + round(w * (b - a)): a registered product,
// then rounding and the final add.
// ----------------------------------------------------------------------------
module pcn_lerp #(
	parameter int F = 16
) (
	input  wire logic               clk,
	input  wire logic [1:0]         en,
	input  wire logic [F:0]         w,
	input  wire logic signed [F+2:0] a,
	input  wire logic signed [F+2:0] b,
	output logic      signed [F+2:0] e
);

	localparam int DW = F + 3;
	localparam int PW = 2 * F + 6;
	localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);

	logic signed [PW-1:0] prod_s1;
	logic signed [DW-1:0] a_s1;
	logic signed [DW-1:0] e_s2;

	logic signed [DW:0]   diff;
	logic signed [F+1:0]  w_sg;
	logic signed [PW-1:0] p_rnd;

	always_comb begin
		diff  = (DW + 1)'(b) - (DW + 1)'(a);
		w_sg  = $signed({1'b0, w});
		p_rnd = (prod_s1 + HALF_P) >>> F;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= PW'(w_sg) * PW'(diff);
			a_s1    <= a;
		end
		if (en[1]) begin
			e_s2 <= a_s1 + DW'(p_rnd);
		end
	end

	assign e = e_s2;

endmodule
`default_nettype wire

FILE: hdl/perlin_cell_noise_eval_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_cell_noise_eval_core
// Improved 3D gradient noise evaluated at one point inside a lattice cell.
// ----------------------------------------------------------------------------
// This block takes one sample item per clock when the output side does not
// stall and returns one result item per sample, in order. Throughput is one
// item every cycle without such a stall. The pipeline is made up of the
// fade weight chain (three dependent multiplies and a rounding stage) followed
// by the three blend levels, each of which is a multiply stage and an add
// stage, plus the output register. Every stage carries its own valid bit and
// a stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and the input stays open while a finished result waits at the
// output as long as some stage is empty. An item with any gradient index
// above eleven returns bad_index set and noise_value zero. Results are signed
// with FRAC_BITS fraction bits and saturate at the limits of the output field.
// ----------------------------------------------------------------------------
module perlin_cell_noise_eval_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [FRAC_BITS-1:0]              frac_x,
	input  wire logic [FRAC_BITS-1:0]              frac_y,
	input  wire logic [FRAC_BITS-1:0]              frac_z,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c000,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c100,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c010,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c110,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c001,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c101,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c011,
	input  wire logic [pcn_pkg::GRAD_W-1:0]        grad_c111,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [FRAC_BITS+1:0]            noise_value,
	output logic                                   bad_index
);

	localparam int F  = FRAC_BITS;
	localparam int DW = F + 3;
	localparam int NS = pcn_pkg::NUM_STAGES;
	localparam logic signed [F+1:0] OUT_MAX = {1'b0, {(F + 1){1'b1}}};
	localparam logic signed [F+1:0] OUT_MIN = {1'b1, {(F + 1){1'b0}}};

	// Stage enables: a stage loads when it is empty or the next stage moves.
	logic [NS:1]   en;
	logic [NS:1]   valid_q;
	logic          tail_full;

	logic [pcn_pkg::GRAD_W-1:0] grad [pcn_pkg::NUM_CORNERS];
	logic [F:0]                 wx, wy, wz;
	logic signed [DW-1:0]       dot   [pcn_pkg::NUM_CORNERS];
	logic                       bad_s4;
	logic signed [DW-1:0]       ex    [4];
	logic signed [DW-1:0]       ey    [2];
	logic signed [DW-1:0]       ez;

	// Weights and the error flag wait for their blend level.
	logic [F:0] wy_s5, wy_s6;
	logic [F:0] wz_s5, wz_s6, wz_s7, wz_s8;
	logic       bad_s5, bad_s6, bad_s7, bad_s8, bad_s9, bad_s10;

	logic signed [F+1:0] noise_s11;
	logic                bad_s11;
	logic signed [F+1:0] noise_c;

	assign grad[0] = grad_c000;
	assign grad[1] = grad_c100;
	assign grad[2] = grad_c010;
	assign grad[3] = grad_c110;
	assign grad[4] = grad_c001;
	assign grad[5] = grad_c101;
	assign grad[6] = grad_c011;
	assign grad[7] = grad_c111;

	// The next stage moves exactly when the output moves or some stage after
	// this one is empty.
	always_comb begin
		tail_full = 1'b1;
		for (int k = NS; k >= 1; k--) begin
			tail_full = tail_full && valid_q[k];
			en[k]     = out_ready || !tail_full;
		end
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Stages 1 to 4: fade weights per axis and corner dot products.
	pcn_fade #(.F(F)) u_fade_x (.clk(clk), .en(en[4:1]), .t(frac_x), .w(wx));
	pcn_fade #(.F(F)) u_fade_y (.clk(clk), .en(en[4:1]), .t(frac_y), .w(wy));
	pcn_fade #(.F(F)) u_fade_z (.clk(clk), .en(en[4:1]), .t(frac_z), .w(wz));

	pcn_grad #(.F(F)) u_grad (
		.clk    (clk),
		.en     (en[4:1]),
		.frac_x (frac_x),
		.frac_y (frac_y),
		.frac_z (frac_z),
		.grad   (grad),
		.dot    (dot),
		.bad    (bad_s4)
	);

	// Stages 5 and 6: blend along x, corners paired by their x bit.
	for (genvar i = 0; i < 4; i++) begin : g_lerp_x
		pcn_lerp #(.F(F)) u_lerp (
			.clk (clk),
			.en  (en[6:5]),
			.w   (wx),
			.a   (dot[2*i]),
			.b   (dot[2*i+1]),
			.e   (ex[i])
		);
	end

	// Stages 7 and 8: blend along y.
	for (genvar i = 0; i < 2; i++) begin : g_lerp_y
		pcn_lerp #(.F(F)) u_lerp (
			.clk (clk),
			.en  (en[8:7]),
			.w   (wy_s6),
			.a   (ex[2*i]),
			.b   (ex[2*i+1]),
			.e   (ey[i])
		);
	end

	// Stages 9 and 10: blend along z.
	pcn_lerp #(.F(F)) u_lerp_z (
		.clk (clk),
		.en  (en[10:9]),
		.w   (wz_s8),
		.a   (ey[0]),
		.b   (ey[1]),
		.e   (ez)
	);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			wy_s5  <= wy;
			wz_s5  <= wz;
			bad_s5 <= bad_s4;
		end
		if (en[6]) begin
			wy_s6  <= wy_s5;
			wz_s6  <= wz_s5;
			bad_s6 <= bad_s5;
		end
		if (en[7]) begin
			wz_s7  <= wz_s6;
			bad_s7 <= bad_s6;
		end
		if (en[8]) begin
			wz_s8  <= wz_s7;
			bad_s8 <= bad_s7;
		end
		if (en[9]) begin
			bad_s9 <= bad_s8;
		end
		if (en[10]) begin
			bad_s10 <= bad_s9;
		end
	end

	// Stage 11: saturate to the output range, or force zero on a bad index.
	always_comb begin
		if (bad_s10) begin
			noise_c = '0;
		end else if (ez[DW-1] != ez[DW-2]) begin
			noise_c = ez[DW-1] ? OUT_MIN : OUT_MAX;
		end else begin
			noise_c = ez[DW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			noise_s11 <= noise_c;
			bad_s11   <= bad_s10;
		end
	end

	assign out_valid   = valid_q[NS];
	assign noise_value = noise_s11;
	assign bad_index   = bad_s11;

endmodule
`default_nettype wire
